[sv/bss_pkg.sv]
// Shared types and constants for the box subtraction slab block.
package bss_pkg;

    localparam int LVL_W = 4;
    localparam int CRD_W = 16;
    localparam int POS_W = 17;
    localparam int EXT_W = 16;
    localparam int TAG_W = 16;

    typedef logic [LVL_W-1:0] level_t;
    typedef logic [CRD_W-1:0] coord_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [EXT_W-1:0] ext_t;
    typedef logic [TAG_W-1:0] tag_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_CUT_LEVEL    = 3'd0;
    localparam cfg_idx_t CFG_CUT_X_OFFSET = 3'd1;
    localparam cfg_idx_t CFG_CUT_Y_OFFSET = 3'd2;
    localparam cfg_idx_t CFG_CUT_Z_OFFSET = 3'd3;
    localparam cfg_idx_t CFG_CUT_X_EXTENT = 3'd4;
    localparam cfg_idx_t CFG_CUT_Y_EXTENT = 3'd5;
    localparam cfg_idx_t CFG_CUT_Z_EXTENT = 3'd6;

    // fragment slots, in emission order; the pass slot is used alone
    localparam int SLOT_N = 7;
    typedef logic [2:0]        slot_t;
    typedef logic [SLOT_N-1:0] slot_mask_t;
    localparam slot_t SLOT_X_LO = 3'd0;
    localparam slot_t SLOT_X_HI = 3'd1;
    localparam slot_t SLOT_Y_LO = 3'd2;
    localparam slot_t SLOT_Y_HI = 3'd3;
    localparam slot_t SLOT_Z_LO = 3'd4;
    localparam slot_t SLOT_Z_HI = 3'd5;
    localparam slot_t SLOT_PASS = 3'd6;

endpackage

[sv/box_subtraction_slabs_core.sv]
// Box minus cut box, emitted as up to six disjoint slabs, one per cycle.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in
//  in      | in_valid in_ready src_*                  | in
//  out     | out_valid out_ready frag_*               | out
//
// An item holds the work register until its last fragment, if any, is loaded;
// the single output register moves one fragment per cycle. A new item is taken
// in the cycle its last fragment loads the output register. Reset clears the cut
// box to zero and empties both registers. out_ready low with out_valid high
// freezes the output register and the fragment walk; cfg_ready is always high.
module box_subtraction_slabs_core #(
    parameter int COORD_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  bss_pkg::cfg_idx_t cfg_index,
    input  bss_pkg::coord_t  cfg_data,

    input  logic             in_valid,
    output logic             in_ready,
    input  bss_pkg::level_t  src_level,
    input  bss_pkg::coord_t  src_x_offset,
    input  bss_pkg::coord_t  src_y_offset,
    input  bss_pkg::coord_t  src_z_offset,
    input  bss_pkg::coord_t  src_x_extent,
    input  bss_pkg::coord_t  src_y_extent,
    input  bss_pkg::coord_t  src_z_extent,
    input  bss_pkg::tag_t    src_tag,

    output logic             out_valid,
    input  logic             out_ready,
    output bss_pkg::level_t  frag_level,
    output bss_pkg::pos_t    frag_x_offset,
    output bss_pkg::pos_t    frag_y_offset,
    output bss_pkg::pos_t    frag_z_offset,
    output bss_pkg::ext_t    frag_x_extent,
    output bss_pkg::ext_t    frag_y_extent,
    output bss_pkg::ext_t    frag_z_extent,
    output bss_pkg::tag_t    frag_tag,
    output logic             frag_last
);
    import bss_pkg::*;

    localparam int CW = (COORD_BITS < CRD_W) ? COORD_BITS : CRD_W;
    localparam coord_t CMASK = CRD_W'((POS_W'(1) << CW) - POS_W'(1));

    // cut box
    level_t cut_level_reg;
    coord_t cut_off_reg [3];
    coord_t cut_ext_reg [3];

    // work register: item being split
    logic       hold_valid_reg;
    slot_mask_t done_reg;
    level_t     lvl_reg;
    coord_t     s_off_reg [3];
    coord_t     s_ext_reg [3];
    tag_t       tag_reg;

    // output register
    logic   out_valid_reg;
    level_t o_level_reg;
    pos_t   o_off_reg [3];
    ext_t   o_ext_reg [3];
    tag_t   o_tag_reg;
    logic   o_last_reg;

    pos_t       slo [3];
    pos_t       shi [3];
    pos_t       ilo [3];
    pos_t       ihi [3];
    pos_t       clo;
    pos_t       chi;
    logic       overlap;
    slot_mask_t full_mask;
    slot_mask_t pending;
    slot_mask_t rest;
    slot_t      sel_idx;
    pos_t       f_lo [3];
    pos_t       f_hi [3];
    pos_t       f_diff [3];
    logic       out_load;
    logic       in_take;
    logic       last_next;

    // bounds, overlap and slab mask
    always_comb
    begin
        overlap = (lvl_reg == cut_level_reg);
        for (int a = 0; a < 3; a++)
        begin
            clo    = POS_W'(cut_off_reg[a] & CMASK);
            chi    = clo + POS_W'(cut_ext_reg[a] & CMASK);
            slo[a] = POS_W'(s_off_reg[a]);
            shi[a] = slo[a] + POS_W'(s_ext_reg[a]);
            ilo[a] = (slo[a] > clo) ? slo[a] : clo;
            ihi[a] = (shi[a] < chi) ? shi[a] : chi;
            if (ilo[a] >= ihi[a])
            begin
                overlap = 1'b0;
            end
        end
        full_mask = '0;
        if (overlap)
        begin
            full_mask[SLOT_X_LO] = slo[0] < ilo[0];
            full_mask[SLOT_X_HI] = ihi[0] < shi[0];
            full_mask[SLOT_Y_LO] = slo[1] < ilo[1];
            full_mask[SLOT_Y_HI] = ihi[1] < shi[1];
            full_mask[SLOT_Z_LO] = slo[2] < ilo[2];
            full_mask[SLOT_Z_HI] = ihi[2] < shi[2];
        end
        else
        begin
            full_mask[SLOT_PASS] = 1'b1;
        end
    end

    assign pending = hold_valid_reg ? (full_mask & ~done_reg) : '0;

    // lowest pending slot goes next
    always_comb
    begin
        sel_idx = SLOT_PASS;
        for (int i = SLOT_N - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                sel_idx = slot_t'(i);
            end
        end
    end

    assign rest = pending & ~(slot_mask_t'(1) << sel_idx);

    always_comb
    begin
        f_lo = slo;
        f_hi = shi;
        unique case (sel_idx)
            SLOT_X_LO:
            begin
                f_hi[0] = ilo[0];
            end
            SLOT_X_HI:
            begin
                f_lo[0] = ihi[0];
            end
            SLOT_Y_LO:
            begin
                f_lo[0] = ilo[0]; f_hi[0] = ihi[0];
                f_hi[1] = ilo[1];
            end
            SLOT_Y_HI:
            begin
                f_lo[0] = ilo[0]; f_hi[0] = ihi[0];
                f_lo[1] = ihi[1];
            end
            SLOT_Z_LO:
            begin
                f_lo[0] = ilo[0]; f_hi[0] = ihi[0];
                f_lo[1] = ilo[1]; f_hi[1] = ihi[1];
                f_hi[2] = ilo[2];
            end
            SLOT_Z_HI:
            begin
                f_lo[0] = ilo[0]; f_hi[0] = ihi[0];
                f_lo[1] = ilo[1]; f_hi[1] = ihi[1];
                f_lo[2] = ihi[2];
            end
            default:
            begin
                // pass slot: source box unchanged
            end
        endcase
        for (int a = 0; a < 3; a++)
        begin
            f_diff[a] = f_hi[a] - f_lo[a];
        end
    end

    assign out_load  = (pending != '0) && (!out_valid_reg || out_ready);
    assign last_next = (rest == '0);
    assign in_ready  = !hold_valid_reg || (pending == '0) || (out_load && last_next);
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            done_reg       <= '0;
            out_valid_reg  <= 1'b0;
            cut_level_reg  <= '0;
            for (int a = 0; a < 3; a++)
            begin
                cut_off_reg[a] <= '0;
                cut_ext_reg[a] <= '0;
            end
        end
        else
        begin
            if (in_take)
            begin
                hold_valid_reg <= 1'b1;
                done_reg       <= '0;
            end
            else if (out_load)
            begin
                done_reg <= done_reg | (slot_mask_t'(1) << sel_idx);
                if (last_next)
                begin
                    hold_valid_reg <= 1'b0;
                end
            end
            else if (hold_valid_reg && pending == '0)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CUT_LEVEL:    cut_level_reg  <= cfg_data[LVL_W-1:0];
                    CFG_CUT_X_OFFSET: cut_off_reg[0] <= cfg_data;
                    CFG_CUT_Y_OFFSET: cut_off_reg[1] <= cfg_data;
                    CFG_CUT_Z_OFFSET: cut_off_reg[2] <= cfg_data;
                    CFG_CUT_X_EXTENT: cut_ext_reg[0] <= cfg_data;
                    CFG_CUT_Y_EXTENT: cut_ext_reg[1] <= cfg_data;
                    CFG_CUT_Z_EXTENT: cut_ext_reg[2] <= cfg_data;
                    default:
                    begin
                        // index beyond the list: ignored
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lvl_reg      <= src_level;
            s_off_reg[0] <= src_x_offset & CMASK;
            s_off_reg[1] <= src_y_offset & CMASK;
            s_off_reg[2] <= src_z_offset & CMASK;
            s_ext_reg[0] <= src_x_extent & CMASK;
            s_ext_reg[1] <= src_y_extent & CMASK;
            s_ext_reg[2] <= src_z_extent & CMASK;
            tag_reg      <= src_tag;
        end
        if (out_load)
        begin
            o_level_reg <= lvl_reg;
            o_tag_reg   <= tag_reg;
            o_last_reg  <= last_next;
            for (int a = 0; a < 3; a++)
            begin
                o_off_reg[a] <= f_lo[a];
                o_ext_reg[a] <= f_diff[a][EXT_W-1:0];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign frag_level    = o_level_reg;
    assign frag_x_offset = o_off_reg[0];
    assign frag_y_offset = o_off_reg[1];
    assign frag_z_offset = o_off_reg[2];
    assign frag_x_extent = o_ext_reg[0];
    assign frag_y_extent = o_ext_reg[1];
    assign frag_z_extent = o_ext_reg[2];
    assign frag_tag      = o_tag_reg;
    assign frag_last     = o_last_reg;

    // only slots of the current item's mask are ever marked done
    a_done_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> ((done_reg & ~full_mask) == '0))
        else $error("done mask holds a slot outside the item's slab mask");

    // nothing loads the output register without an item at work
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_valid_reg |-> !out_load)
        else $error("fragment loaded with no item in the work register");

    // loading the final fragment frees the work register for a new item
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |-> in_ready)
        else $error("work register not freed on final fragment");

    // an item freed with no new one leaves the work register empty
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && in_ready && !in_valid) |=> !hold_valid_reg)
        else $error("work register stayed busy after release");

endmodule

[sim/slab_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the box subtraction slab block: cut-box copy, slab prediction and checking.
package slab_scoreboard_pkg;
    import bss_pkg::*;

    typedef struct {
        level_t level;
        coord_t off [3];
        coord_t ext [3];
        tag_t   tag;
    } box_t;

    typedef struct {
        level_t level;
        pos_t   off [3];
        ext_t   ext [3];
        tag_t   tag;
        logic   last;
    } frag_t;

    class slab_scoreboard;
        level_t      cut_lvl;
        coord_t      cut_off [3];
        coord_t      cut_ext [3];
        frag_t       pending_frags [$];
        int unsigned errors;
        int unsigned n_boxes;
        int unsigned n_pass;
        int unsigned n_split;
        int unsigned n_inside;
        int unsigned n_slabs;
        int unsigned n_checked;

        function new();
            cut_lvl = '0;
            foreach (cut_off[a])
            begin
                cut_off[a] = '0;
                cut_ext[a] = '0;
            end
            errors    = 0;
            n_boxes   = 0;
            n_pass    = 0;
            n_split   = 0;
            n_inside  = 0;
            n_slabs   = 0;
            n_checked = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, coord_t data);
            case (idx)
                CFG_CUT_LEVEL:    cut_lvl    = data[LVL_W-1:0];
                CFG_CUT_X_OFFSET: cut_off[0] = data;
                CFG_CUT_Y_OFFSET: cut_off[1] = data;
                CFG_CUT_Z_OFFSET: cut_off[2] = data;
                CFG_CUT_X_EXTENT: cut_ext[0] = data;
                CFG_CUT_Y_EXTENT: cut_ext[1] = data;
                CFG_CUT_Z_EXTENT: cut_ext[2] = data;
                default: ;
            endcase
        endfunction

        function frag_t make_frag(box_t b, pos_t lo [3], pos_t hi [3], logic last);
            frag_t f;
            f.level = b.level;
            f.tag   = b.tag;
            f.last  = last;
            for (int a = 0; a < 3; a++)
            begin
                f.off[a] = lo[a];
                f.ext[a] = ext_t'(hi[a] - lo[a]);
            end
            return f;
        endfunction

        // works out the fragments of one accepted box and queues them
        function void add_box(box_t b);
            pos_t  slo [3], shi [3], clo [3], chi [3], ilo [3], ihi [3];
            pos_t  lo [3], hi [3];
            frag_t held;
            logic  hit;
            int    n;
            int    ax;
            n_boxes++;
            hit = (b.level == cut_lvl);
            n = 0;
            for (int a = 0; a < 3; a++)
            begin
                slo[a] = {1'b0, b.off[a]};
                shi[a] = slo[a] + {1'b0, b.ext[a]};
                clo[a] = {1'b0, cut_off[a]};
                chi[a] = clo[a] + {1'b0, cut_ext[a]};
                ilo[a] = (slo[a] > clo[a]) ? slo[a] : clo[a];
                ihi[a] = (shi[a] < chi[a]) ? shi[a] : chi[a];
                if (ilo[a] >= ihi[a])
                    hit = 1'b0;
            end
            if (!hit)
            begin
                pending_frags.push_back(make_frag(b, slo, shi, 1'b1));
                n_pass++;
                return;
            end
            // slab k is cut along axis k/2, low side for even k; axes before it are
            // narrowed to the overlap, axes after it keep the full source span
            for (int k = 0; k < 6; k++)
            begin
                ax = k / 2;
                for (int a = 0; a < 3; a++)
                begin
                    if (a < ax)
                    begin
                        lo[a] = ilo[a];
                        hi[a] = ihi[a];
                    end
                    else if (a > ax)
                    begin
                        lo[a] = slo[a];
                        hi[a] = shi[a];
                    end
                    else if (k % 2 == 0)
                    begin
                        lo[a] = slo[a];
                        hi[a] = ilo[a];
                    end
                    else
                    begin
                        lo[a] = ihi[a];
                        hi[a] = shi[a];
                    end
                end
                if (lo[ax] < hi[ax])
                begin
                    if (n > 0)
                        pending_frags.push_back(held);
                    held = make_frag(b, lo, hi, 1'b0);
                    n++;
                end
            end
            if (n == 0)
                n_inside++;
            else
            begin
                held.last = 1'b1;
                pending_frags.push_back(held);
                n_split++;
                n_slabs += n;
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_frag(frag_t got);
            frag_t want;
            string ax_name;
            if (pending_frags.size() == 0)
            begin
                $error("fragment with tag %0h arrived with nothing pending", got.tag);
                errors++;
                return;
            end
            want = pending_frags.pop_front();
            n_checked++;
            cmp_field("frag_level", want.level, got.level);
            for (int a = 0; a < 3; a++)
            begin
                ax_name = (a == 0) ? "x" : (a == 1) ? "y" : "z";
                cmp_field($sformatf("frag_%s_offset", ax_name), want.off[a], got.off[a]);
                cmp_field($sformatf("frag_%s_extent", ax_name), want.ext[a], got.ext[a]);
            end
            cmp_field("frag_tag", want.tag, got.tag);
            cmp_field("frag_last", want.last, got.last);
        endfunction
    endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Top-level bench for box_subtraction_slabs_core: directed and random boxes against a slab predictor.
module tb_top;
    import bss_pkg::*;
    import slab_scoreboard_pkg::*;

    localparam int       CYCLE_LIMIT   = 400000;
    localparam int       HOLD_CYCLES   = 300;
    localparam int       SETTLE_CYCLES = 8;
    localparam int       RAND_PHASES   = 8;
    localparam int       PHASE_BOXES   = 55;
    localparam cfg_idx_t CFG_UNUSED    = 3'd7;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;

    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = CFG_CUT_LEVEL;
    coord_t   cfg_data  = '0;

    logic     in_valid = 1'b0;
    logic     in_ready;
    level_t   src_level    = '0;
    coord_t   src_x_offset = '0;
    coord_t   src_y_offset = '0;
    coord_t   src_z_offset = '0;
    coord_t   src_x_extent = '0;
    coord_t   src_y_extent = '0;
    coord_t   src_z_extent = '0;
    tag_t     src_tag      = '0;

    logic     out_valid;
    logic     out_ready = 1'b0;
    level_t   frag_level;
    pos_t     frag_x_offset;
    pos_t     frag_y_offset;
    pos_t     frag_z_offset;
    ext_t     frag_x_extent;
    ext_t     frag_y_extent;
    ext_t     frag_z_extent;
    tag_t     frag_tag;
    logic     frag_last;

    slab_scoreboard sb = new();
    logic           no_idle  = 1'b0;
    logic           hold_req = 1'b0;
    int unsigned    cycle_count  = 0;
    int unsigned    cut_settings = 0;

    box_subtraction_slabs_core dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic box_t mk_box(level_t lvl, int x, int y, int z,
                                    int ex, int ey, int ez, tag_t tag);
        box_t b;
        b.level  = lvl;
        b.off[0] = coord_t'(x);
        b.off[1] = coord_t'(y);
        b.off[2] = coord_t'(z);
        b.ext[0] = coord_t'(ex);
        b.ext[1] = coord_t'(ey);
        b.ext[2] = coord_t'(ez);
        b.tag    = tag;
        return b;
    endfunction

    // a coordinate just below, on, inside, or just above the cut span
    function automatic int pick_point(int lo_c, int span);
        case ($urandom_range(0, 4))
            0:       return lo_c - int'($urandom_range(1, 40));
            1:       return lo_c;
            2:       return lo_c + int'($urandom_range(0, span));
            3:       return lo_c + span;
            default: return lo_c + span + int'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, coord_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic load_cut(level_t lvl, coord_t off [3], coord_t ext [3]);
        cfg_idx_t off_idx [3];
        cfg_idx_t ext_idx [3];
        coord_t   lvl_word;
        off_idx = '{CFG_CUT_X_OFFSET, CFG_CUT_Y_OFFSET, CFG_CUT_Z_OFFSET};
        ext_idx = '{CFG_CUT_X_EXTENT, CFG_CUT_Y_EXTENT, CFG_CUT_Z_EXTENT};
        // junk above the level bits must be dropped
        lvl_word = coord_t'($urandom);
        lvl_word[LVL_W-1:0] = lvl;
        write_reg(CFG_CUT_LEVEL, lvl_word);
        for (int a = 0; a < 3; a++)
        begin
            write_reg(off_idx[a], off[a]);
            write_reg(ext_idx[a], ext[a]);
        end
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_UNUSED, coord_t'($urandom));
        cfg_valid <= 1'b0;
        cut_settings++;
    endtask

    task automatic send_box(box_t b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        src_level    <= b.level;
        src_x_offset <= b.off[0];
        src_y_offset <= b.off[1];
        src_z_offset <= b.off[2];
        src_x_extent <= b.ext[0];
        src_y_extent <= b.ext[1];
        src_z_extent <= b.ext[2];
        src_tag      <= b.tag;
        do @(posedge clk); while (!in_ready);
        sb.add_box(b);
    endtask

    // boxes inside the cut leave nothing pending while the block still works
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_frags.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : sink
        frag_t       got;
        int unsigned idle;
        int unsigned hold_left;
        logic        hold_done;
        idle      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.level  = frag_level;
                got.off[0] = frag_x_offset;
                got.off[1] = frag_y_offset;
                got.off[2] = frag_z_offset;
                got.ext[0] = frag_x_extent;
                got.ext[1] = frag_y_extent;
                got.ext[2] = frag_z_extent;
                got.tag    = frag_tag;
                got.last   = frag_last;
                sb.check_frag(got);
                idle = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (idle > 0)
            begin
                idle--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        box_t   b;
        coord_t off [3];
        coord_t ext [3];
        level_t lvl;
        int     p0;
        int     p1;
        int     t;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cut is empty after reset, so boxes pass whole
        send_box(mk_box(4'd0, 0, 0, 0, 10, 10, 10, 16'h1234));
        send_box(mk_box(4'd0, 5, 5, 5, 1, 1, 1, 16'h8001));
        drain();

        off = '{16'd1000, 16'd2000, 16'd3000};
        ext = '{16'd100, 16'd200, 16'd300};
        load_cut(4'd3, off, ext);
        send_box(mk_box(4'd3, 1010, 2010, 3010, 10, 10, 10, 16'h0001));     // inside
        send_box(mk_box(4'd3, 1000, 2000, 3000, 100, 200, 300, 16'h0002)); // same as cut
        send_box(mk_box(4'd3, 900, 1900, 2900, 300, 400, 500, 16'hffff));  // all six slabs
        send_box(mk_box(4'd4, 900, 1900, 2900, 300, 400, 500, 16'h0004));  // other level
        send_box(mk_box(4'd3, 1100, 2000, 3000, 50, 50, 50, 16'h0005));    // touches in x
        send_box(mk_box(4'd3, 1000, 2000, 3000, 50, 50, 0, 16'h0006));     // flat in z
        send_box(mk_box(4'd3, 950, 2050, 3050, 100, 10, 10, 16'h0007));
        send_box(mk_box(4'd3, 1050, 2050, 3050, 100, 10, 10, 16'h0008));
        send_box(mk_box(4'd3, 1010, 1950, 3050, 10, 100, 10, 16'h0009));
        send_box(mk_box(4'd3, 1010, 2150, 3050, 10, 100, 10, 16'h000a));
        send_box(mk_box(4'd3, 1010, 2050, 2950, 10, 10, 100, 16'h000b));
        send_box(mk_box(4'd3, 1010, 2050, 3250, 10, 10, 100, 16'h000c));
        send_box(mk_box(4'd15, 65535, 65535, 65535, 65535, 65535, 65535, 16'hffff));
        send_box(mk_box(4'd3, 0, 0, 0, 0, 0, 0, 16'h0000));
        drain();

        // cut at the top of the range: upper slabs start above 16 bits
        off = '{16'd65530, 16'd65530, 16'd65530};
        ext = '{16'd10, 16'd10, 16'd10};
        load_cut(4'd9, off, ext);
        send_box(mk_box(4'd9, 65000, 65000, 65000, 65535, 65535, 65535, 16'h5a5a));
        send_box(mk_box(4'd9, 65535, 65535, 65535, 65535, 65535, 65535, 16'ha5a5));
        send_box(mk_box(4'd9, 65532, 65532, 65532, 2, 2, 2, 16'h0f0f));
        drain();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lvl = 4'd15;
                    off = '{16'hffff, 16'hffff, 16'hffff};
                    ext = '{16'hffff, 16'hffff, 16'hffff};
                end
                1:
                begin
                    lvl = 4'd0;
                    off = '{16'd0, 16'd0, 16'd0};
                    ext = '{16'hffff, 16'hffff, 16'hffff};
                end
                default:
                begin
                    lvl = level_t'($urandom);
                    for (int a = 0; a < 3; a++)
                    begin
                        off[a] = coord_t'($urandom);
                        ext[a] = (p == 2) ? 16'd1 : coord_t'($urandom_range(1, 4000));
                    end
                    // a zero-size axis makes the cut remove nothing
                    if (p == 3)
                        ext[$urandom_range(0, 2)] = '0;
                end
            endcase
            load_cut(lvl, off, ext);
            no_idle <= (p == 5 || p == 6);
            if (p == 5)
                hold_req <= 1'b1;
            for (int i = 0; i < PHASE_BOXES; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    b = mk_box(level_t'($urandom), $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, tag_t'($urandom));
                else
                begin
                    b.level = ($urandom_range(0, 9) == 0) ? level_t'($urandom) : lvl;
                    b.tag   = tag_t'($urandom);
                    for (int a = 0; a < 3; a++)
                    begin
                        p0 = pick_point(int'(off[a]), int'(ext[a]));
                        p1 = pick_point(int'(off[a]), int'(ext[a]));
                        if (p0 > p1)
                        begin
                            t  = p0;
                            p0 = p1;
                            p1 = t;
                        end
                        if ($urandom_range(0, 9) == 0)
                            p1 = p0;
                        if (p0 < 0)
                            p0 = 0;
                        if (p0 > 65535)
                            p0 = 65535;
                        p1 = p1 - p0;
                        if (p1 < 0)
                            p1 = 0;
                        if (p1 > 65535)
                            p1 = 65535;
                        b.off[a] = coord_t'(p0);
                        b.ext[a] = coord_t'(p1);
                    end
                end
                send_box(b);
            end
            drain();
        end

        $display("Ran %0d boxes under %0d cut settings, with random idling and a %0d-cycle output hold.",
                 sb.n_boxes, cut_settings, HOLD_CYCLES);
        $display("%0d passed whole, %0d split into %0d slabs, %0d fell inside; %0d fragments checked.",
                 sb.n_pass, sb.n_split, sb.n_slabs, sb.n_inside, sb.n_checked);
        if (sb.errors == 0 && sb.pending_frags.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
sv/bss_pkg.sv
sv/box_subtraction_slabs_core.sv
sim/slab_scoreboard_pkg.sv
sim/tb_top.sv
